/* rtl/etcb_pkg.sv */
// Shared types and constants for the event trace capture buffer.
// No dependencies; every other file in rtl but etcb_checker uses it by scoped names.
package etcb_pkg;

  // Fixed field widths of the command and result interface.
  localparam int FILL_W  = 11;
  localparam int IDX_W   = 10;
  localparam int COUNT_W = 11;
  localparam int DATA_W  = 32;

  // Packet events keep only the low 24 bits of the packet identifier.
  localparam logic [31:0] PKT_ID_MASK = 32'h00FF_FFFF;

  // Reset value of the fill length register.
  localparam logic [FILL_W-1:0] FILL_RESET = 11'd1024;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_READ   = 2'd1,
    CMD_START  = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_WRAP_MODE   = 2'd0,
    REG_TRACE_CLASS = 2'd1,
    REG_TYPE_MASK   = 2'd2,
    REG_FILL_LENGTH = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLASS_NONE   = 2'd0,
    CLASS_EVENT  = 2'd1,
    CLASS_PACKET = 2'd2,
    CLASS_UNUSED = 2'd3
  } trace_class_t;

  typedef enum logic {
    BK_RUN,
    BK_READ
  } back_state_t;

  // Configuration register file.
  typedef struct packed {
    logic              wrap_mode;
    logic [1:0]        trace_class;
    logic [31:0]       type_mask;
    logic [FILL_W-1:0] fill_length;
  } cfg_t;

  // One stored trace entry.
  typedef struct packed {
    logic [4:0]        etype;
    logic [2:0]        cpu;
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] stamp;
    logic [DATA_W-1:0] access;
    logic [DATA_W-1:0] activate;
  } entry_t;

  // One classified request as it travels from front end to back end.
  typedef struct packed {
    cmd_t             cmd;
    logic             eligible;
    entry_t           ev;
    logic [IDX_W-1:0] read_index;
  } item_t;

  // Result of one request.
  typedef struct packed {
    logic               done;
    logic               entry_valid;
    entry_t             ev;
    logic [COUNT_W-1:0] entry_count;
    logic               wrapped_flag;
    logic               capture_armed;
    logic               recorded;
  } result_t;

endpackage

/* rtl/etcb_front.sv */
// Front end: accepts requests and classifies record requests against the
// type mask and trace class. Depends on etcb_pkg.
module etcb_front (
  input  logic                          start,
  input  logic                          full,
  input  etcb_pkg::cfg_t                cfg,
  input  logic [1:0]                    command,
  input  logic [4:0]                    event_type,
  input  logic                          is_packet_event,
  input  logic [2:0]                    cpu_number,
  input  logic [31:0]                   event_id,
  input  logic [31:0]                   address,
  input  logic [31:0]                   timestamp,
  input  logic [31:0]                   access_count,
  input  logic [31:0]                   activate_count,
  input  logic [etcb_pkg::IDX_W-1:0]    read_index,
  output logic                          push,
  output etcb_pkg::item_t               item
);

  logic mask_ok;
  logic class_ok;

  // A request enters the queue whenever there is room for it.
  assign push = start && !full;

  // Packet events skip the class check; ordinary events need event tracing.
  assign mask_ok  = cfg.type_mask[event_type];
  assign class_ok = is_packet_event ||
                    (etcb_pkg::trace_class_t'(cfg.trace_class) == etcb_pkg::CLASS_EVENT);

  // Build the queued request, with the packet identifier already trimmed.
  always_comb begin
    item.cmd         = etcb_pkg::cmd_t'(command);
    item.eligible    = mask_ok && class_ok;
    item.ev.etype    = event_type;
    item.ev.cpu      = cpu_number;
    item.ev.id       = event_id;
    item.ev.addr     = address;
    item.ev.stamp    = timestamp;
    item.ev.access   = is_packet_event ? (access_count & etcb_pkg::PKT_ID_MASK)
                                       : access_count;
    item.ev.activate = activate_count;
    item.read_index  = read_index;
  end

endmodule

/* rtl/etcb_queue.sv */
// Two-entry request queue between the front end and the back end.
// Depends on etcb_pkg for the request type.
module etcb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  etcb_pkg::item_t item_in,
  input  logic            pop,
  output etcb_pkg::item_t item_out,
  output logic            empty,
  output logic            full
);

  etcb_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign empty    = (count == 2'd0);
  assign full     = (count == 2'd2);
  assign item_out = slots[rd_ptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Storage slots carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

endmodule

/* rtl/etcb_back.sv */
// Back end: holds the capture state and the trace memory, executes one
// request at a time and drives the result. Depends on etcb_pkg.
module etcb_back #(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  etcb_pkg::cfg_t    cfg,
  input  etcb_pkg::item_t   item,
  input  logic              empty,
  output logic              pop,
  output etcb_pkg::result_t result
);

  localparam int AW  = $clog2(DEPTH);
  localparam int PW  = $clog2(DEPTH + 1);
  localparam int LW  = (PW > etcb_pkg::FILL_W) ? PW : etcb_pkg::FILL_W;
  localparam int SW  = ((PW > etcb_pkg::IDX_W) ? PW : etcb_pkg::IDX_W) + 1;

  etcb_pkg::back_state_t state;
  etcb_pkg::back_state_t state_next;

  logic [PW-1:0]    write_pointer;
  logic [PW-1:0]    write_pointer_next;
  logic             wrapped;
  logic             wrapped_next;
  logic             capturing;
  logic             capturing_next;
  logic             done;
  logic             done_next;
  logic             entry_valid;
  logic             recorded;

  etcb_pkg::entry_t mem [DEPTH];
  etcb_pkg::entry_t mem_q;

  logic [LW-1:0]    fill_ext;
  logic [LW-1:0]    len_ext;
  logic [PW-1:0]    len;
  logic [LW-1:0]    held_ext;

  logic [PW-1:0]    wslot;
  logic [PW-1:0]    wslot_inc;
  logic             do_write;
  logic             rec;

  logic [PW-1:0]    oldest;
  logic [SW-1:0]    sum;
  logic [SW-1:0]    rslot_ext;
  logic             hit;
  logic             is_read;

  // Length in use: zero acts as one, anything above the memory acts as full.
  assign fill_ext = LW'(cfg.fill_length);
  assign len_ext  = (fill_ext == '0) ? LW'(1) :
                    ((fill_ext > LW'(DEPTH)) ? LW'(DEPTH) : fill_ext);
  assign len      = len_ext[PW-1:0];

  assign pop     = !empty && (state == etcb_pkg::BK_RUN);
  assign is_read = (item.cmd == etcb_pkg::CMD_READ);

  // Read address, counted from the oldest entry.
  always_comb begin
    oldest = (write_pointer >= len) ? '0 : write_pointer;
    sum    = SW'(oldest) + SW'(item.read_index);
    if (wrapped) begin
      hit       = SW'(item.read_index) < SW'(len);
      rslot_ext = (sum >= SW'(len)) ? (sum - SW'(len)) : sum;
    end else begin
      hit       = SW'(item.read_index) < SW'(write_pointer);
      rslot_ext = SW'(item.read_index);
    end
    hit = hit && (rslot_ext < SW'(DEPTH));
  end

  // Capture state update for the request at the head of the queue.
  always_comb begin
    write_pointer_next = write_pointer;
    wrapped_next       = wrapped;
    capturing_next     = capturing;
    do_write           = 1'b0;
    rec                = 1'b0;
    wslot              = write_pointer;
    wslot_inc          = write_pointer + PW'(1);
    unique case (item.cmd)
      etcb_pkg::CMD_RECORD: begin
        if (capturing && item.eligible) begin
          if (cfg.wrap_mode) begin
            // Circular mode: a pointer past the length restarts at slot zero.
            if (write_pointer >= len) begin
              wslot        = '0;
              wrapped_next = 1'b1;
            end
            wslot_inc = wslot + PW'(1);
            do_write  = 1'b1;
            rec       = 1'b1;
            if (wslot_inc >= len) begin
              write_pointer_next = '0;
              wrapped_next       = 1'b1;
            end else begin
              write_pointer_next = wslot_inc;
            end
          end else if (write_pointer >= len) begin
            capturing_next = 1'b0;
          end else begin
            // Stop mode: disarm once the last slot is filled.
            do_write           = 1'b1;
            rec                = 1'b1;
            write_pointer_next = wslot_inc;
            if (wslot_inc >= len) begin
              capturing_next = 1'b0;
            end
          end
        end
      end
      etcb_pkg::CMD_READ: begin
      end
      etcb_pkg::CMD_START: begin
        write_pointer_next = '0;
        wrapped_next       = 1'b0;
        capturing_next     = 1'b1;
      end
      etcb_pkg::CMD_STOP: begin
        capturing_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: a read passes through the BK_READ state for the memory access.
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    unique case (state)
      etcb_pkg::BK_RUN: begin
        if (pop) begin
          if (is_read) begin
            state_next = etcb_pkg::BK_READ;
          end else begin
            done_next = 1'b1;
          end
        end
      end
      etcb_pkg::BK_READ: begin
        state_next = etcb_pkg::BK_RUN;
        done_next  = 1'b1;
      end
      default: begin
        state_next = etcb_pkg::BK_RUN;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etcb_pkg::BK_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Capture state and result flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      wrapped       <= 1'b0;
      capturing     <= 1'b0;
      done          <= 1'b0;
      entry_valid   <= 1'b0;
      recorded      <= 1'b0;
    end else begin
      done <= done_next;
      if (pop) begin
        write_pointer <= write_pointer_next;
        wrapped       <= wrapped_next;
        capturing     <= capturing_next;
        entry_valid   <= is_read && hit;
        recorded      <= rec;
      end
    end
  end

  // Trace memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (pop && do_write) begin
      mem[wslot[AW-1:0]] <= item.ev;
    end
    if (pop && is_read) begin
      mem_q <= mem[rslot_ext[AW-1:0]];
    end
  end

  // Result fields; entry data is zero unless a read hit a held entry.
  assign held_ext = wrapped ? LW'(len) : LW'(write_pointer);

  always_comb begin
    result.done          = done;
    result.entry_valid   = entry_valid;
    result.ev            = entry_valid ? mem_q : '0;
    result.entry_count   = held_ext[etcb_pkg::COUNT_W-1:0];
    result.wrapped_flag  = wrapped;
    result.capture_armed = capturing;
    result.recorded      = recorded;
  end

endmodule

/* rtl/event_trace_capture_buffer.sv */
// Event trace capture buffer top level: configuration registers, front end,
// request queue and back end. Depends on etcb_pkg, etcb_front, etcb_queue, etcb_back.
//
// A request is taken at a clock edge with start high and busy low, and gives
// exactly one result, shown for one cycle with done high; the receiver cannot
// stall. Record, start and stop requests execute at one per cycle while no
// read holds the back end; a read holds it in BK_READ because the trace
// memory has a single registered read port, so no new request leaves the
// queue until the read is through. busy rises only when the two-entry
// request queue is full. The trace memory holds DEPTH entries and is not
// cleared at reset; there is no clearing pass.
module event_trace_capture_buffer #(
  parameter int DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  command,
  input  logic [4:0]  event_type,
  input  logic        is_packet_event,
  input  logic [2:0]  cpu_number,
  input  logic [31:0] event_id,
  input  logic [31:0] address,
  input  logic [31:0] timestamp,
  input  logic [31:0] access_count,
  input  logic [31:0] activate_count,
  input  logic [9:0]  read_index,
  output logic        done,
  output logic        entry_valid,
  output logic [4:0]  entry_type,
  output logic [2:0]  entry_cpu,
  output logic [31:0] entry_id,
  output logic [31:0] entry_address,
  output logic [31:0] entry_time,
  output logic [31:0] entry_access,
  output logic [31:0] entry_activate,
  output logic [10:0] entry_count,
  output logic        wrapped_flag,
  output logic        capture_armed,
  output logic        recorded
);

  etcb_pkg::cfg_t    cfg;
  etcb_pkg::item_t   front_item;
  etcb_pkg::item_t   head_item;
  etcb_pkg::result_t result;
  logic              push;
  logic              pop;
  logic              empty;
  logic              full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wrap_mode   <= 1'b0;
      cfg.trace_class <= 2'd0;
      cfg.type_mask   <= '0;
      cfg.fill_length <= etcb_pkg::FILL_RESET;
    end else if (cfg_write) begin
      unique case (etcb_pkg::reg_idx_t'(cfg_index))
        etcb_pkg::REG_WRAP_MODE:   cfg.wrap_mode   <= cfg_data[0];
        etcb_pkg::REG_TRACE_CLASS: cfg.trace_class <= cfg_data[1:0];
        etcb_pkg::REG_TYPE_MASK:   cfg.type_mask   <= cfg_data;
        etcb_pkg::REG_FILL_LENGTH: cfg.fill_length <= cfg_data[etcb_pkg::FILL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy = full;

  etcb_front u_front (
    .start           (start),
    .full            (full),
    .cfg             (cfg),
    .command         (command),
    .event_type      (event_type),
    .is_packet_event (is_packet_event),
    .cpu_number      (cpu_number),
    .event_id        (event_id),
    .address         (address),
    .timestamp       (timestamp),
    .access_count    (access_count),
    .activate_count  (activate_count),
    .read_index      (read_index),
    .push            (push),
    .item            (front_item)
  );

  etcb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (front_item),
    .pop      (pop),
    .item_out (head_item),
    .empty    (empty),
    .full     (full)
  );

  etcb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (head_item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // Result ports.
  assign done           = result.done;
  assign entry_valid    = result.entry_valid;
  assign entry_type     = result.ev.etype;
  assign entry_cpu      = result.ev.cpu;
  assign entry_id       = result.ev.id;
  assign entry_address  = result.ev.addr;
  assign entry_time     = result.ev.stamp;
  assign entry_access   = result.ev.access;
  assign entry_activate = result.ev.activate;
  assign entry_count    = result.entry_count;
  assign wrapped_flag   = result.wrapped_flag;
  assign capture_armed  = result.capture_armed;
  assign recorded       = result.recorded;

endmodule

/* rtl/etcb_checker.sv */
// Port-level checks for the event trace capture buffer, bound to the top level.
// Depends on event_trace_capture_buffer for the bind target.
module etcb_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        entry_valid,
  input logic        recorded,
  input logic [10:0] entry_count
);

  // A result is never both a stored record and a read hit.
  assert property (@(posedge clk) disable iff (rst)
    done |-> !(recorded && entry_valid))
    else $error("result flags both a record and a read");

  // The queue can only fill after a request was offered.
  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // A stored record always leaves at least one entry held.
  assert property (@(posedge clk) disable iff (rst)
    (done && recorded) |-> (entry_count != 11'd0))
    else $error("record stored but entry count is zero");

  // A read hit implies the buffer holds entries.
  assert property (@(posedge clk) disable iff (rst)
    (done && entry_valid) |-> (entry_count != 11'd0))
    else $error("read hit on an empty buffer");

  // No result is shown in the cycle that follows a reset cycle.
  assert property (@(posedge clk)
    rst |=> !done)
    else $error("result shown right after reset");

endmodule

bind event_trace_capture_buffer etcb_checker u_etcb_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .entry_valid (entry_valid),
  .recorded    (recorded),
  .entry_count (entry_count)
);
